[rtl/wspc_pkg.sv]
// Package for the wheel sync PI correction block.
// Holds the beat structs, register indexes and fixed-point constants.
// No dependencies.
package wspc_pkg;

  // drive levels are Q14: full scale is 1.0
  localparam int unsigned FULL_SCALE = 16384;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned INTEG_W    = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  // reset gains, Q16 drive units per count
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd1288490;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd32212;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 1'd1;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [15:0] right_target;
    logic signed [15:0] left_target;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] right_drive;
    logic signed [15:0] left_drive;
  } out_beat_t;

endpackage

[rtl/wheel_sync_pi_correction.sv]
// Wheel sync PI correction, top level.
// Depends on wspc_pkg for beat structs, register indexes and constants.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one sample beat:
//   both encoder counts, both targets and a restart flag. Result channel
//   (out_valid / out_stall / out_data) returns one beat per sample with the
//   corrected right drive and the left target passed through.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   prop_gain (index 0) or integ_gain (index 1); cfg_ready is always high.
//   Write gains only while no sample is in flight.
// Timing:
//   Six register stages: input, error and integral, products, low sum,
//   correction, drive clamp. One sample is accepted every cycle while
//   in_stall is low; the integral update is a combinational 48-bit
//   saturating add, which sets that rate.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline, clears the
//   integral and loads the default gains.
// Backpressure:
//   When out_stall holds the result, stages ahead fill up in order; once
//   every stage is full, in_stall rises. No beat is dropped.
module wheel_sync_pi_correction (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wspc_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wspc_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wspc_pkg::GAIN_W-1:0]         cfg_data
);

  // gain registers
  logic [wspc_pkg::GAIN_W-1:0] prop_gain_r;
  logic [wspc_pkg::GAIN_W-1:0] integ_gain_r;

  // stage valids and ready chain
  logic va_r, vb_r, vc_r, vd_r, ve_r, out_valid_r;
  logic rdy_o, rdy_e, rdy_d, rdy_c, rdy_b, rdy_a;

  // stage A: input register
  wspc_pkg::in_beat_t a_r;

  // stage B: error and updated integral
  logic signed [32:0]                  err_b_r;
  logic signed [wspc_pkg::INTEG_W-1:0] integ_b_r;
  logic signed [15:0]                  rt_b_r, lt_b_r;
  logic                                fwd_b_r;

  // running integral state
  logic signed [wspc_pkg::INTEG_W-1:0] integ_r;

  // stage C: products
  logic signed [56:0] ep_c_r;
  logic signed [55:0] hig_c_r;
  logic        [39:0] log_c_r;
  logic signed [15:0] rt_c_r, lt_c_r;
  logic               fwd_c_r;

  // stage D: low partial sum
  logic signed [57:0] s1_d_r;
  logic signed [55:0] hig_d_r;
  logic signed [15:0] rt_d_r, lt_d_r;
  logic               fwd_d_r;

  // stage E: full correction
  logic signed [56:0] corr_e_r;
  logic signed [15:0] rt_e_r, lt_e_r;
  logic               fwd_e_r;

  // output register
  wspc_pkg::out_beat_t out_data_r;

  // combinational next values
  logic signed [32:0]                  err_nxt;
  logic                                fwd_nxt;
  logic signed [wspc_pkg::INTEG_W-1:0] integ_base;
  logic signed [wspc_pkg::INTEG_W:0]   integ_sum;
  logic signed [wspc_pkg::INTEG_W-1:0] integ_nxt;
  logic signed [24:0]                  pg_s, ig_s;
  logic signed [31:0]                  integ_hi;
  logic        [15:0]                  integ_lo;
  logic signed [57:0]                  ep_full;
  logic signed [55:0]                  hig_nxt;
  logic        [39:0]                  log_nxt;
  logic signed [57:0]                  s1_nxt;
  logic signed [56:0]                  corr_nxt;
  logic signed [57:0]                  rt_x, corr_x, drive_full;
  logic signed [15:0]                  drive_nxt;

  // ready chain: a stage takes a beat when empty or when it drains
  always_comb begin
    rdy_o = !out_valid_r || !out_stall;
    rdy_e = !ve_r || rdy_o;
    rdy_d = !vd_r || rdy_e;
    rdy_c = !vc_r || rdy_d;
    rdy_b = !vb_r || rdy_c;
    rdy_a = !va_r || rdy_b;
  end

  assign in_stall  = !rdy_a;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // error and saturating integral update
  always_comb begin
    fwd_nxt = (a_r.right_target > 16'sd0);
    if (fwd_nxt) begin
      err_nxt = 33'(a_r.left_count) - 33'(a_r.right_count);
    end else begin
      err_nxt = 33'(a_r.right_count) - 33'(a_r.left_count);
    end
    integ_base = a_r.restart ? '0 : integ_r;
    integ_sum  = (wspc_pkg::INTEG_W+1)'(integ_base) + (wspc_pkg::INTEG_W+1)'(err_nxt);
    if (integ_sum[wspc_pkg::INTEG_W] != integ_sum[wspc_pkg::INTEG_W-1]) begin
      integ_nxt = integ_sum[wspc_pkg::INTEG_W] ?
                  {1'b1, {(wspc_pkg::INTEG_W-1){1'b0}}} :
                  {1'b0, {(wspc_pkg::INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_sum[wspc_pkg::INTEG_W-1:0];
    end
  end

  // products: integral split into a signed high 32 bits and a low 16 bits
  always_comb begin
    pg_s     = $signed({1'b0, prop_gain_r});
    ig_s     = $signed({1'b0, integ_gain_r});
    integ_hi = integ_b_r[wspc_pkg::INTEG_W-1:16];
    integ_lo = integ_b_r[15:0];
    ep_full  = err_b_r * pg_s;
    hig_nxt  = integ_hi * ig_s;
    log_nxt  = integ_lo * integ_gain_r;
  end

  // low sum, then correction as one floor of the Q16 total
  always_comb begin
    s1_nxt   = 58'(ep_c_r) + $signed({18'd0, log_c_r});
    corr_nxt = 57'(hig_d_r) + 57'(s1_d_r >>> 16);
  end

  // apply correction by direction, clamp to full scale
  always_comb begin
    rt_x   = 58'(rt_e_r);
    corr_x = 58'(corr_e_r);
    drive_full = fwd_e_r ? (rt_x + corr_x) : (rt_x - corr_x);
    if (drive_full > 58'sd16384) begin
      drive_nxt = 16'(wspc_pkg::FULL_SCALE);
    end else if (drive_full < -58'sd16384) begin
      drive_nxt = -16'(wspc_pkg::FULL_SCALE);
    end else begin
      drive_nxt = drive_full[15:0];
    end
  end

  // control state: valids, integral, gains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      vc_r         <= 1'b0;
      vd_r         <= 1'b0;
      ve_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
      prop_gain_r  <= wspc_pkg::PROP_GAIN_RST;
      integ_gain_r <= wspc_pkg::INTEG_GAIN_RST;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
      if (rdy_o) out_valid_r <= ve_r;
      // advance the integral once per sample leaving stage A
      if (va_r && rdy_b) integ_r <= integ_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          wspc_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
          wspc_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, loaded as each stage advances
  always_ff @(posedge clk) begin
    if (rdy_a) a_r <= in_data;
    if (rdy_b) begin
      err_b_r   <= err_nxt;
      integ_b_r <= integ_nxt;
      rt_b_r    <= a_r.right_target;
      lt_b_r    <= a_r.left_target;
      fwd_b_r   <= fwd_nxt;
    end
    if (rdy_c) begin
      ep_c_r  <= ep_full[56:0];
      hig_c_r <= hig_nxt;
      log_c_r <= log_nxt;
      rt_c_r  <= rt_b_r;
      lt_c_r  <= lt_b_r;
      fwd_c_r <= fwd_b_r;
    end
    if (rdy_d) begin
      s1_d_r  <= s1_nxt;
      hig_d_r <= hig_c_r;
      rt_d_r  <= rt_c_r;
      lt_d_r  <= lt_c_r;
      fwd_d_r <= fwd_c_r;
    end
    if (rdy_e) begin
      corr_e_r <= corr_nxt;
      rt_e_r   <= rt_d_r;
      lt_e_r   <= lt_d_r;
      fwd_e_r  <= fwd_d_r;
    end
    if (rdy_o) begin
      out_data_r.right_drive <= drive_nxt;
      out_data_r.left_drive  <= lt_e_r;
    end
  end

endmodule

[rtl/wspc_check.sv]
// Port-level checker for the wheel sync PI correction block.
// Depends on wspc_pkg; bound to wheel_sync_pi_correction at the end.
module wspc_check (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input wspc_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input wspc_pkg::out_beat_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output stage never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // right drive stays within full scale
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.right_drive <= $signed(16'(wspc_pkg::FULL_SCALE))) &&
                  (out_data.right_drive >= -$signed(16'(wspc_pkg::FULL_SCALE))))
    else $error("right drive outside full scale");

endmodule

bind wheel_sync_pi_correction wspc_check u_wspc_check (.*);
